### sv/tza_pkg.sv
// Shared types, constants and helpers for the tagged zone allocator.
package tza_pkg;

  localparam int ARENA_BYTES  = 65536;
  localparam int HEADER_BYTES = 16;
  localparam int MAX_BLOCKS   = 63;
  localparam int NODE_COUNT   = MAX_BLOCKS + 1;
  localparam int IDX_W        = 6;
  localparam int GUARD_LIMIT  = 4 * NODE_COUNT;

  localparam logic [IDX_W-1:0] HEAD_NODE = IDX_W'(MAX_BLOCKS);

  localparam logic [2:0] CMD_ALLOC  = 3'd0;
  localparam logic [2:0] CMD_FREE   = 3'd1;
  localparam logic [2:0] CMD_FREE_TAGS = 3'd2;
  localparam logic [2:0] CMD_SET_TAG = 3'd3;
  localparam logic [2:0] CMD_SIZE   = 3'd4;
  localparam logic [2:0] CMD_USED   = 3'd5;

  localparam logic [1:0] KIND_NOTICE = 2'd0;
  localparam logic [1:0] KIND_DONE   = 2'd1;
  localparam logic [1:0] KIND_ANSWER = 2'd2;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NO_FIT    = 3'd1;
  localparam logic [2:0] ST_DBL_FREE  = 3'd2;
  localparam logic [2:0] ST_NEED_OWN  = 3'd3;
  localparam logic [2:0] ST_NO_DESC   = 3'd4;

  localparam logic CFG_PURGE = 1'b0;
  localparam logic CFG_MINFRAG = 1'b1;

  typedef struct packed {
    logic [15:0]      start;
    logic [16:0]      bytes;
    logic             used;
    logic [7:0]       owner;
    logic [7:0]       tag;
    logic [IDX_W-1:0] nxt;
    logic [IDX_W-1:0] prv;
  } desc_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  status;
    logic [15:0] addr;
    logic [7:0]  owner;
    logic [16:0] value;
    logic        last;
  } res_t;

  typedef enum logic [5:0] {
    S_INIT0, S_INIT1, S_IDLE,
    S_A0, S_A1, S_A2, S_AL_CHK, S_AL_EV, S_AL_BR,
    S_AL_PG1, S_AL_PG2, S_AL_PG3, S_AL_PG4,
    S_AS0, S_AS1, S_AS2,
    S_HEAD, S_DISP, S_FB_CHK, S_FB_EV,
    S_T2_CHK, S_T2_EV, S_T2_AF, S_S5_CHK, S_S5_EV,
    S_F0, S_F1, S_F2, S_F3, S_F4, S_F5, S_F6,
    S_FIN
  } state_t;

  function automatic res_t mk_res(input logic [1:0] kind, input logic [2:0] status,
                                  input logic [15:0] addr, input logic [7:0] owner,
                                  input logic [16:0] value, input logic last);
    res_t r;
    r.kind   = kind;
    r.status = status;
    r.addr   = addr;
    r.owner  = owner;
    r.value  = value;
    r.last   = last;
    return r;
  endfunction

  function automatic logic [15:0] payload_of(input desc_t d);
    return d.start + 16'(HEADER_BYTES);
  endfunction

endpackage

### sv/tza_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tza_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### sv/tagged_zone_allocator_core.sv
// Zone allocator core: descriptor list in RAM walked by a sequencer.
//
//  channel | ports                        | contents
//  --------+------------------------------+----------------------------------
//  in      | in_tvalid/tready/tdata/tuser | one command word
//  out     | out_tvalid/tready/tdata/tuser/tlast | notices, completion, answers
//  cfg     | cfg_we/cfg_addr/cfg_wdata    | purge_level (0), min_fragment (1)
//
// One descriptor is read per RAM cycle; a list walk alternates a check state
// that issues the read with an evaluate state, allocate adds S_AL_BR to skip
// a static block, a free with coalescing runs in S_F0 to S_F6 and a purge
// runs such a free in the walk. After reset S_INIT0 and S_INIT1 write the
// initial arena and list head; no word is taken meanwhile. One command is
// worked at a time; the next word is taken once the final result sits in out_r.
module tagged_zone_allocator_core
  import tza_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // req_bytes, block_tag_in, owner_id, payload_addr,
                                  // tag_low, tag_high
  input  logic [2:0]  in_tuser,   // cmd
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // status, result_addr, owner_out, value, zero pad
  output logic [1:0]  out_tuser,  // kind
  output logic        out_tlast,
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [15:0] cfg_wdata
);

  state_t state_r, state_nxt, ret_r, ret_nxt;
  logic [2:0]  cmd_r, cmd_nxt;
  logic [16:0] size_r, size_nxt;
  logic [7:0]  tag_r, tag_nxt, own_r, own_nxt, lo_r, lo_nxt, hi_r, hi_nxt;
  logic [15:0] addr_r, addr_nxt;
  logic [7:0]  purge_r, purge_nxt;
  logic [15:0] minf_r, minf_nxt;
  logic [NODE_COUNT-1:0] spare_r, spare_nxt;
  logic [IDX_W-1:0] rover_r, rover_nxt, cur_r, cur_nxt, b_r, b_nxt, p_r, p_nxt;
  logic [IDX_W-1:0] n_r, n_nxt, base_r, base_nxt, rv_r, rv_nxt;
  logic [IDX_W-1:0] start_r, start_nxt, bp_r, bp_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic [5:0]  k_r, k_nxt;
  logic [8:0]  guard_r, guard_nxt;
  logic [16:0] sum_r, sum_nxt;
  desc_t recb_r, recb_nxt, recp_r, recp_nxt, recbase_r, recbase_nxt;
  res_t  pend_r, pend_nxt, out_r, out_nxt;
  logic  out_valid_r, out_valid_nxt;

  logic  ram_we, ram_re;
  logic [IDX_W-1:0] ram_waddr, ram_raddr;
  desc_t ram_wdata, rd;
  logic  emit_v, can_emit;
  res_t  emit_d;
  desc_t w, dn;
  logic [16:0] extra;

  tza_ram #(.WIDTH($bits(desc_t)), .DEPTH(NODE_COUNT)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (rd)
  );

  function automatic logic [IDX_W-1:0] first_spare(input logic [NODE_COUNT-1:0] s);
    logic [IDX_W-1:0] r;
    r = '0;
    for (int i = MAX_BLOCKS - 1; i >= 0; i--) begin
      if (s[i]) r = IDX_W'(i);
    end
    return r;
  endfunction

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_r.kind;
  assign out_tlast  = out_r.last;
  assign out_tdata  = {4'd0, out_r.value, out_r.owner, out_r.addr, out_r.status};
  assign can_emit   = !out_valid_r || out_tready;

  always_comb begin
    state_nxt = state_r;  ret_nxt = ret_r;  cmd_nxt = cmd_r;  size_nxt = size_r;
    tag_nxt = tag_r;  own_nxt = own_r;  lo_nxt = lo_r;  hi_nxt = hi_r;  addr_nxt = addr_r;
    purge_nxt = purge_r;  minf_nxt = minf_r;  spare_nxt = spare_r;  rover_nxt = rover_r;
    cur_nxt = cur_r;  b_nxt = b_r;  p_nxt = p_r;  n_nxt = n_r;  base_nxt = base_r;
    rv_nxt = rv_r;  start_nxt = start_r;  bp_nxt = bp_r;  cnt_nxt = cnt_r;  k_nxt = k_r;
    guard_nxt = guard_r;  sum_nxt = sum_r;  recb_nxt = recb_r;  recp_nxt = recp_r;
    recbase_nxt = recbase_r;  pend_nxt = pend_r;
    ram_we = 1'b0;  ram_waddr = '0;  ram_wdata = '0;  ram_re = 1'b0;  ram_raddr = '0;
    emit_v = 1'b0;  emit_d = '0;
    w = rd;  dn = '0;
    extra = recbase_r.bytes - size_r;

    if (cfg_we) begin
      if (cfg_addr == CFG_PURGE) purge_nxt = cfg_wdata[7:0];
      else minf_nxt = cfg_wdata;
    end

    case (state_r)
      S_INIT0: begin
        dn.bytes = 17'(ARENA_BYTES);
        dn.nxt = HEAD_NODE;
        dn.prv = HEAD_NODE;
        ram_we = 1'b1;  ram_waddr = '0;  ram_wdata = dn;
        state_nxt = S_INIT1;
      end
      S_INIT1: begin
        dn.used = 1'b1;
        ram_we = 1'b1;  ram_waddr = HEAD_NODE;  ram_wdata = dn;
        state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_tvalid) begin
          cmd_nxt  = in_tuser;
          size_nxt = ({1'b0, in_tdata[15:0]} + 17'(HEADER_BYTES + 3)) & ~17'd3;
          tag_nxt  = in_tdata[23:16];
          own_nxt  = in_tdata[31:24];
          addr_nxt = in_tdata[47:32];
          lo_nxt   = in_tdata[55:48];
          hi_nxt   = in_tdata[63:56];
          if (in_tuser == CMD_ALLOC) state_nxt = S_A0;
          else if (in_tuser <= CMD_USED) state_nxt = S_HEAD;
        end
      end
      S_A0: begin
        if (own_r == 8'd0 && tag_r >= purge_r) begin
          pend_nxt = mk_res(KIND_DONE, ST_NEED_OWN, '0, '0, '0, 1'b1);
          state_nxt = S_FIN;
        end else begin
          ram_re = 1'b1;  ram_raddr = rover_r;
          state_nxt = S_A1;
        end
      end
      S_A1: begin
        recbase_nxt = rd;
        base_nxt = rover_r;
        ram_re = 1'b1;  ram_raddr = rd.prv;
        state_nxt = S_A2;
      end
      S_A2: begin
        if (!rd.used) begin
          base_nxt = recbase_r.prv;
          rv_nxt = recbase_r.prv;
          recbase_nxt = rd;
          start_nxt = rd.prv;
        end else begin
          rv_nxt = base_r;
          start_nxt = recbase_r.prv;
        end
        guard_nxt = '0;
        k_nxt = '0;
        state_nxt = S_AL_CHK;
      end
      S_AL_CHK: begin
        if (rv_r == start_r || guard_r > 9'(GUARD_LIMIT) || k_r == 6'(MAX_BLOCKS)) begin
          pend_nxt = mk_res(KIND_DONE, ST_NO_FIT, '0, '0, '0, 1'b1);
          state_nxt = S_FIN;
        end else begin
          guard_nxt = guard_r + 9'd1;
          ram_re = 1'b1;  ram_raddr = rv_r;
          state_nxt = S_AL_EV;
        end
      end
      S_AL_EV: begin
        if (rd.used) begin
          if (rv_r == HEAD_NODE || rd.tag < purge_r) begin
            rv_nxt = rd.nxt;
            base_nxt = rd.nxt;
            ram_re = 1'b1;  ram_raddr = rd.nxt;
            state_nxt = S_AL_BR;
          end else if (can_emit) begin
            emit_v = 1'b1;
            emit_d = mk_res(KIND_NOTICE, ST_OK, payload_of(rd), rd.owner, '0, 1'b0);
            k_nxt = k_r + 6'd1;
            recb_nxt = rd;
            b_nxt = rv_r;
            ram_re = 1'b1;  ram_raddr = base_r;
            state_nxt = S_AL_PG1;
          end
        end else begin
          rv_nxt = rd.nxt;
          if (!recbase_r.used && recbase_r.bytes >= size_r) state_nxt = S_AS0;
          else state_nxt = S_AL_CHK;
        end
      end
      S_AL_BR: begin
        recbase_nxt = rd;
        if (!rd.used && rd.bytes >= size_r) state_nxt = S_AS0;
        else state_nxt = S_AL_CHK;
      end
      S_AL_PG1: begin
        bp_nxt = rd.prv;
        ret_nxt = S_AL_PG2;
        state_nxt = S_F0;
      end
      S_AL_PG2: begin
        ram_re = 1'b1;  ram_raddr = bp_r;
        state_nxt = S_AL_PG3;
      end
      S_AL_PG3: begin
        base_nxt = rd.nxt;
        ram_re = 1'b1;  ram_raddr = rd.nxt;
        state_nxt = S_AL_PG4;
      end
      S_AL_PG4: begin
        recbase_nxt = rd;
        rv_nxt = rd.nxt;
        if (!rd.used && rd.bytes >= size_r) state_nxt = S_AS0;
        else state_nxt = S_AL_CHK;
      end
      S_AS0: begin
        if (extra > {1'b0, minf_r} && |spare_r[MAX_BLOCKS-1:0]) begin
          n_nxt = first_spare(spare_r);
          spare_nxt[first_spare(spare_r)] = 1'b0;
          dn.start = recbase_r.start + size_r[15:0];
          dn.bytes = extra;
          dn.prv = base_r;
          dn.nxt = recbase_r.nxt;
          ram_we = 1'b1;  ram_waddr = first_spare(spare_r);  ram_wdata = dn;
          ram_re = 1'b1;  ram_raddr = recbase_r.nxt;
          state_nxt = S_AS1;
        end else begin
          state_nxt = S_AS2;
        end
      end
      S_AS1: begin
        w.prv = n_r;
        ram_we = 1'b1;  ram_waddr = recbase_r.nxt;  ram_wdata = w;
        recbase_nxt.nxt = n_r;
        recbase_nxt.bytes = size_r;
        state_nxt = S_AS2;
      end
      S_AS2: begin
        w = recbase_r;
        w.used = 1'b1;
        w.owner = own_r;
        w.tag = tag_r;
        ram_we = 1'b1;  ram_waddr = base_r;  ram_wdata = w;
        rover_nxt = recbase_r.nxt;
        pend_nxt = mk_res(KIND_DONE, ST_OK, payload_of(recbase_r), own_r, '0, 1'b1);
        state_nxt = S_FIN;
      end
      S_HEAD: begin
        ram_re = 1'b1;  ram_raddr = HEAD_NODE;
        state_nxt = S_DISP;
      end
      S_DISP: begin
        cur_nxt = rd.nxt;
        cnt_nxt = '0;
        k_nxt = '0;
        sum_nxt = '0;
        if (cmd_r == CMD_FREE_TAGS) state_nxt = S_T2_CHK;
        else if (cmd_r == CMD_USED) state_nxt = S_S5_CHK;
        else state_nxt = S_FB_CHK;
      end
      S_FB_CHK: begin
        if (cur_r == HEAD_NODE || cnt_r == 7'(MAX_BLOCKS)) begin
          pend_nxt = mk_res((cmd_r == CMD_SIZE) ? KIND_ANSWER : KIND_DONE, ST_NO_DESC,
                            addr_r, '0, '0, 1'b1);
          state_nxt = S_FIN;
        end else begin
          ram_re = 1'b1;  ram_raddr = cur_r;
          state_nxt = S_FB_EV;
        end
      end
      S_FB_EV: begin
        if (payload_of(rd) != addr_r) begin
          cur_nxt = rd.nxt;
          cnt_nxt = cnt_r + 7'd1;
          state_nxt = S_FB_CHK;
        end else if (cmd_r == CMD_FREE) begin
          if (!rd.used) begin
            pend_nxt = mk_res(KIND_DONE, ST_DBL_FREE, addr_r, '0, '0, 1'b1);
            state_nxt = S_FIN;
          end else begin
            pend_nxt = mk_res(KIND_DONE, ST_OK, addr_r, rd.owner, '0, 1'b1);
            recb_nxt = rd;
            b_nxt = cur_r;
            ret_nxt = S_FIN;
            state_nxt = S_F0;
          end
        end else if (cmd_r == CMD_SET_TAG) begin
          w.tag = tag_r;
          ram_we = 1'b1;  ram_waddr = cur_r;  ram_wdata = w;
          pend_nxt = mk_res(KIND_DONE, ST_OK, addr_r, rd.owner, '0, 1'b1);
          state_nxt = S_FIN;
        end else begin
          pend_nxt = mk_res(KIND_ANSWER, ST_OK, addr_r, rd.owner,
                            (rd.bytes > 17'(HEADER_BYTES)) ?
                            rd.bytes - 17'(HEADER_BYTES) : 17'd0, 1'b1);
          state_nxt = S_FIN;
        end
      end
      S_T2_CHK: begin
        if (cur_r == HEAD_NODE || cnt_r == 7'(NODE_COUNT) || k_r == 6'(MAX_BLOCKS)) begin
          pend_nxt = mk_res(KIND_DONE, ST_OK, '0, '0, '0, 1'b1);
          state_nxt = S_FIN;
        end else begin
          ram_re = 1'b1;  ram_raddr = cur_r;
          state_nxt = S_T2_EV;
        end
      end
      S_T2_EV: begin
        if (rd.used && rd.tag >= lo_r && rd.tag <= hi_r) begin
          if (can_emit) begin
            emit_v = 1'b1;
            emit_d = mk_res(KIND_NOTICE, ST_OK, payload_of(rd), rd.owner, '0, 1'b0);
            k_nxt = k_r + 6'd1;
            cnt_nxt = cnt_r + 7'd1;
            recb_nxt = rd;
            b_nxt = cur_r;
            ret_nxt = S_T2_AF;
            state_nxt = S_F0;
          end
        end else begin
          cur_nxt = rd.nxt;
          cnt_nxt = cnt_r + 7'd1;
          state_nxt = S_T2_CHK;
        end
      end
      S_T2_AF: begin
        cur_nxt = recb_r.nxt;
        state_nxt = S_T2_CHK;
      end
      S_S5_CHK: begin
        if (cur_r == HEAD_NODE || cnt_r == 7'(NODE_COUNT)) begin
          pend_nxt = mk_res(KIND_ANSWER, ST_OK, '0, '0, sum_r, 1'b1);
          state_nxt = S_FIN;
        end else begin
          ram_re = 1'b1;  ram_raddr = cur_r;
          state_nxt = S_S5_EV;
        end
      end
      S_S5_EV: begin
        if (rd.used && rd.tag != 8'd0) sum_nxt = sum_r + rd.bytes;
        cur_nxt = rd.nxt;
        cnt_nxt = cnt_r + 7'd1;
        state_nxt = S_S5_CHK;
      end
      // free with coalescing; b_r/recb_r hold the block, result left there
      S_F0: begin
        recb_nxt.used = 1'b0;
        recb_nxt.owner = '0;
        p_nxt = recb_r.prv;
        ram_re = 1'b1;  ram_raddr = recb_r.prv;
        state_nxt = S_F1;
      end
      S_F1: begin
        if (p_r != HEAD_NODE && !rd.used) begin
          recp_nxt = rd;
          recp_nxt.bytes = rd.bytes + recb_r.bytes;
          recp_nxt.nxt = recb_r.nxt;
          w = recb_r;
          w.tag = '0;
          ram_we = 1'b1;  ram_waddr = b_r;  ram_wdata = w;
          spare_nxt[b_r] = 1'b1;
          if (rover_r == b_r) rover_nxt = p_r;
          ram_re = 1'b1;  ram_raddr = recb_r.nxt;
          state_nxt = S_F2;
        end else begin
          state_nxt = S_F3;
        end
      end
      S_F2: begin
        w.prv = p_r;
        ram_we = 1'b1;  ram_waddr = recb_r.nxt;  ram_wdata = w;
        recb_nxt = recp_r;
        b_nxt = p_r;
        state_nxt = S_F3;
      end
      S_F3: begin
        ram_re = 1'b1;  ram_raddr = recb_r.nxt;
        state_nxt = S_F4;
      end
      S_F4: begin
        if (recb_r.nxt != HEAD_NODE && !rd.used) begin
          recb_nxt.bytes = recb_r.bytes + rd.bytes;
          recb_nxt.nxt = rd.nxt;
          if (rover_r == recb_r.nxt) rover_nxt = b_r;
          spare_nxt[recb_r.nxt] = 1'b1;
          w.used = 1'b0;
          w.owner = '0;
          w.tag = '0;
          ram_we = 1'b1;  ram_waddr = recb_r.nxt;  ram_wdata = w;
          ram_re = 1'b1;  ram_raddr = rd.nxt;
          state_nxt = S_F5;
        end else begin
          ram_we = 1'b1;  ram_waddr = b_r;  ram_wdata = recb_r;
          state_nxt = ret_r;
        end
      end
      S_F5: begin
        w.prv = b_r;
        ram_we = 1'b1;  ram_waddr = recb_r.nxt;  ram_wdata = w;
        state_nxt = S_F6;
      end
      S_F6: begin
        ram_we = 1'b1;  ram_waddr = b_r;  ram_wdata = recb_r;
        state_nxt = ret_r;
      end
      S_FIN: begin
        if (can_emit) begin
          emit_v = 1'b1;
          emit_d = pend_r;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    out_valid_nxt = out_valid_r && !out_tready;
    out_nxt = out_r;
    if (emit_v) begin
      out_valid_nxt = 1'b1;
      out_nxt = emit_d;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT0;
      ret_r       <= S_IDLE;
      purge_r     <= 8'd100;
      minf_r      <= 16'd64;
      spare_r     <= {1'b0, {(MAX_BLOCKS - 1){1'b1}}, 1'b0};
      rover_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ret_r       <= ret_nxt;
      purge_r     <= purge_nxt;
      minf_r      <= minf_nxt;
      spare_r     <= spare_nxt;
      rover_r     <= rover_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r     <= cmd_nxt;
    size_r    <= size_nxt;
    tag_r     <= tag_nxt;
    own_r     <= own_nxt;
    lo_r      <= lo_nxt;
    hi_r      <= hi_nxt;
    addr_r    <= addr_nxt;
    cur_r     <= cur_nxt;
    b_r       <= b_nxt;
    p_r       <= p_nxt;
    n_r       <= n_nxt;
    base_r    <= base_nxt;
    rv_r      <= rv_nxt;
    start_r   <= start_nxt;
    bp_r      <= bp_nxt;
    cnt_r     <= cnt_nxt;
    k_r       <= k_nxt;
    guard_r   <= guard_nxt;
    sum_r     <= sum_nxt;
    recb_r    <= recb_nxt;
    recp_r    <= recp_nxt;
    recbase_r <= recbase_nxt;
    pend_r    <= pend_nxt;
    out_r     <= out_nxt;
  end

endmodule
